// ===== sv/irpd_pkg.sv =====
// Shared types and constants of the infrared pulse-distance decoder.
`default_nettype none
package irpd_pkg;

  localparam int unsigned TimeW = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_LEADER_LOW  = 3'd0;
  localparam logic [RegIdxW-1:0] REG_LEADER_HIGH = 3'd1;
  localparam logic [RegIdxW-1:0] REG_REPEAT_LOW  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_REPEAT_HIGH = 3'd3;
  localparam logic [RegIdxW-1:0] REG_ONE_LOW     = 3'd4;
  localparam logic [RegIdxW-1:0] REG_ONE_HIGH    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_GAP_LIMIT   = 3'd6;

  localparam logic [TimeW-1:0] LEADER_LOW_RST  = 16'd1300;
  localparam logic [TimeW-1:0] LEADER_HIGH_RST = 16'd1400;
  localparam logic [TimeW-1:0] REPEAT_LOW_RST  = 16'd1100;
  localparam logic [TimeW-1:0] REPEAT_HIGH_RST = 16'd1200;
  localparam logic [TimeW-1:0] ONE_LOW_RST     = 16'd200;
  localparam logic [TimeW-1:0] ONE_HIGH_RST    = 16'd240;
  localparam logic [TimeW-1:0] GAP_LIMIT_RST   = 16'd2000;

  localparam logic EVENT_FRAME  = 1'b0;
  localparam logic EVENT_REPEAT = 1'b1;

  // Classification of one edge interval, independent of decoder phase.
  typedef struct packed {
    logic gap;
    logic leader;
    logic rpt;
    logic one;
  } class_t;

endpackage
`default_nettype wire

// ===== sv/irpd_front.sv =====
// Front end: configuration registers, interval computation and window classification.
`default_nettype none
module irpd_front (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           cfg_we,
  input  wire  [irpd_pkg::RegIdxW-1:0]  cfg_index,
  input  wire  [irpd_pkg::TimeW-1:0]    cfg_data,
  input  wire                           push,
  input  wire  [irpd_pkg::TimeW-1:0]    edge_time,
  output irpd_pkg::class_t              cls
);
  import irpd_pkg::*;

  logic [TimeW-1:0] leader_low, leader_high, repeat_low, repeat_high;
  logic [TimeW-1:0] one_low, one_high, gap_limit;
  logic [TimeW-1:0] last_edge;
  logic [TimeW-1:0] interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      leader_low  <= LEADER_LOW_RST;
      leader_high <= LEADER_HIGH_RST;
      repeat_low  <= REPEAT_LOW_RST;
      repeat_high <= REPEAT_HIGH_RST;
      one_low     <= ONE_LOW_RST;
      one_high    <= ONE_HIGH_RST;
      gap_limit   <= GAP_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEADER_LOW:  leader_low  <= cfg_data;
        REG_LEADER_HIGH: leader_high <= cfg_data;
        REG_REPEAT_LOW:  repeat_low  <= cfg_data;
        REG_REPEAT_HIGH: repeat_high <= cfg_data;
        REG_ONE_LOW:     one_low     <= cfg_data;
        REG_ONE_HIGH:    one_high    <= cfg_data;
        REG_GAP_LIMIT:   gap_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge <= '0;
    end else if (push) begin
      last_edge <= edge_time;
    end
  end

  assign interval = edge_time - last_edge;

  always_comb begin
    cls.gap    = (interval >= gap_limit);
    cls.leader = (interval > leader_low) && (interval < leader_high);
    cls.rpt    = (interval > repeat_low) && (interval < repeat_high);
    cls.one    = (interval > one_low) && (interval < one_high);
  end

endmodule
`default_nettype wire

// ===== sv/irpd_queue.sv =====
// Two-entry queue of classified edges between the front end and the back end.
`default_nettype none
module irpd_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  irpd_pkg::class_t  push_data,
  output logic              full,
  input  wire               pop,
  output logic              not_empty,
  output irpd_pkg::class_t  pop_data
);
  import irpd_pkg::*;

  class_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

endmodule
`default_nettype wire

// ===== sv/irpd_back.sv =====
// Back end: decoder phase, bit assembly, counters and the registered result.
`default_nettype none
module irpd_back #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cmd_valid,
  input  irpd_pkg::class_t             cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         event_kind,
  output logic [irpd_pkg::WordW-1:0]   frame_word,
  output logic [irpd_pkg::CntW-1:0]    frames_seen,
  output logic [irpd_pkg::CntW-1:0]    repeats_seen
);
  import irpd_pkg::*;

  localparam int unsigned BcW = $clog2(FRAME_BITS + 1);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WAIT  = 2'd1;
  localparam logic [1:0] PH_FRAME = 2'd2;

  logic [1:0]       phase, phase_next;
  logic [BcW-1:0]   bit_count, bit_count_next, bc_inc;
  logic [WordW-1:0] shift_word, shift_word_next;
  logic [CntW-1:0]  frame_total, frame_total_next;
  logic [CntW-1:0]  repeat_total, repeat_total_next;
  logic             emit;
  logic             emit_kind;
  logic [WordW-1:0] emit_word;

  assign cmd_pop = cmd_valid && (!out_valid || out_ready);
  assign bc_inc  = bit_count + 1'b1;

  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_word_next   = shift_word;
    frame_total_next  = frame_total;
    repeat_total_next = repeat_total;
    emit              = 1'b0;
    emit_kind         = EVENT_FRAME;
    emit_word         = '0;
    case (phase)
      PH_WAIT: begin
        if (cmd.gap) begin
          phase_next = PH_WAIT;
        end else if (cmd.leader) begin
          phase_next        = PH_FRAME;
          bit_count_next    = '0;
          shift_word_next   = '0;
          repeat_total_next = '0;
        end else if (cmd.rpt) begin
          repeat_total_next = repeat_total + 1'b1;
          emit              = 1'b1;
          emit_kind         = EVENT_REPEAT;
        end
      end
      PH_FRAME: begin
        shift_word_next = {shift_word[WordW-2:0], cmd.one};
        bit_count_next  = bc_inc;
        if (bc_inc == BcW'(FRAME_BITS)) begin
          emit             = 1'b1;
          emit_kind        = EVENT_FRAME;
          emit_word        = shift_word_next;
          frame_total_next = frame_total + 1'b1;
          phase_next       = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_count    <= '0;
      shift_word   <= '0;
      frame_total  <= '0;
      repeat_total <= '0;
    end else if (cmd_pop) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_word   <= shift_word_next;
      frame_total  <= frame_total_next;
      repeat_total <= repeat_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      event_kind   <= emit_kind;
      frame_word   <= emit_word;
      frames_seen  <= frame_total;
      repeats_seen <= repeat_total_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ir_pulse_distance_decoder_top.sv =====
// Top level of the infrared pulse-distance frame decoder.
`default_nettype none
// Takes one edge timestamp per clock cycle while in_ready is high. The front end
// computes the interval to the previous edge and classifies it against the
// configured windows in the cycle of acceptance; a two-entry queue carries the
// classification to the back end, which updates the frame state and loads the
// registered result at the clock edge that pops the item. A stalled output
// holds the back end while the queue keeps accepting items until it holds two.
module ir_pulse_distance_decoder_top #(
  parameter int unsigned FRAME_BITS = 32
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [irpd_pkg::RegIdxW-1:0] cfg_index,
  input  wire  [irpd_pkg::TimeW-1:0]   cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [irpd_pkg::TimeW-1:0]   edge_time,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         event_kind,
  output logic [irpd_pkg::WordW-1:0]   frame_word,
  output logic [irpd_pkg::CntW-1:0]    frames_seen,
  output logic [irpd_pkg::CntW-1:0]    repeats_seen
);
  import irpd_pkg::*;

  class_t front_cls;
  class_t queue_cls;
  logic   push;
  logic   full;
  logic   not_empty;
  logic   pop;

  assign in_ready = !full;
  assign push     = in_valid && in_ready;

  irpd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .edge_time (edge_time),
    .cls       (front_cls)
  );

  irpd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_cls),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (queue_cls)
  );

  irpd_back #(
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (not_empty),
    .cmd          (queue_cls),
    .cmd_pop      (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_kind   (event_kind),
    .frame_word   (frame_word),
    .frames_seen  (frames_seen),
    .repeats_seen (repeats_seen)
  );

endmodule
`default_nettype wire

// ===== sv/irpd_checker.sv =====
// Port-level checker for the infrared pulse-distance decoder and its bind.
`default_nettype none
module irpd_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire                          event_kind,
  input wire [irpd_pkg::WordW-1:0]    frame_word,
  input wire [irpd_pkg::CntW-1:0]     frames_seen,
  input wire [irpd_pkg::CntW-1:0]     repeats_seen
);
  import irpd_pkg::*;

  // A stalled result must hold its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
      $stable(frame_word) && $stable(frames_seen) && $stable(repeats_seen))
    else $error("stalled result changed");

  // After reset the queue is empty and nothing is presented.
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("state not clean after reset");

  // A repeat item carries no frame word.
  a_repeat_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EVENT_REPEAT) |-> frame_word == '0)
    else $error("repeat item with nonzero word");

  // A repeat item always reports at least one repeat.
  a_repeat_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == EVENT_REPEAT) |-> repeats_seen != '0)
    else $error("repeat item with zero repeat count");

endmodule

bind ir_pulse_distance_decoder_top irpd_checker u_irpd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .event_kind   (event_kind),
  .frame_word   (frame_word),
  .frames_seen  (frames_seen),
  .repeats_seen (repeats_seen)
);
`default_nettype wire

// ===== sim/tb_ir_pulse_distance_decoder_top.sv =====
// Self-checking testbench for the infrared pulse-distance decoder top level.
module tb_ir_pulse_distance_decoder_top;
  import irpd_pkg::*;

  localparam int FrameBits = 32;
  localparam logic [RegIdxW-1:0] REG_SPARE = 3'd7;

  typedef enum logic [1:0] {DEC_IDLE, DEC_ARMED, DEC_FRAME} dec_phase_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word;
    logic [CntW-1:0]  frames;
    logic [CntW-1:0]  repeats;
  } ir_event_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [RegIdxW-1:0] cfg_index = '0;
  logic [TimeW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [TimeW-1:0]   edge_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               event_kind;
  logic [WordW-1:0]   frame_word;
  logic [CntW-1:0]    frames_seen;
  logic [CntW-1:0]    repeats_seen;

  ir_pulse_distance_decoder_top #(.FRAME_BITS(FrameBits)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .edge_time(edge_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_kind(event_kind),
    .frame_word(frame_word),
    .frames_seen(frames_seen),
    .repeats_seen(repeats_seen)
  );

  logic [TimeW-1:0] edge_q[$];
  ir_event_t        event_q[$];
  logic [TimeW-1:0] cfg_mirror [0:REG_GAP_LIMIT];

  dec_phase_t       dec_phase = DEC_IDLE;
  logic [TimeW-1:0] prev_edge = '0;
  int unsigned      bits_in = 0;
  logic [WordW-1:0] word_acc = '0;
  logic [CntW-1:0]  frame_count = '0;
  logic [CntW-1:0]  repeat_count = '0;

  int err_count = 0;
  int n_accepted = 0;
  int n_emitted = 0;
  int n_frames_checked = 0;
  int n_repeats_checked = 0;
  int n_settings = 1;
  int n_queued = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 80;
  bit hold_for_drain = 1'b0;

  logic [TimeW-1:0] stamp = '0;
  bit               gen_armed = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bit band_hit(input logic [TimeW-1:0] v, input logic [RegIdxW-1:0] lo_reg);
    return v > cfg_mirror[lo_reg] && v < cfg_mirror[lo_reg + 1];
  endfunction

  // Advances the decoder state by one edge; returns 1 when the edge yields an event.
  function automatic bit decode_edge(input logic [TimeW-1:0] t);
    logic [TimeW-1:0] iv;
    ir_event_t        ev;
    iv = t - prev_edge;
    prev_edge = t;
    case (dec_phase)
      DEC_ARMED: begin
        if (iv >= cfg_mirror[REG_GAP_LIMIT]) begin
          dec_phase = DEC_ARMED;
        end else if (band_hit(iv, REG_LEADER_LOW)) begin
          dec_phase = DEC_FRAME;
          bits_in = 0;
          word_acc = '0;
          repeat_count = '0;
        end else if (band_hit(iv, REG_REPEAT_LOW)) begin
          repeat_count = repeat_count + 1;
          ev = {EVENT_REPEAT, {WordW{1'b0}}, frame_count, repeat_count};
          event_q.push_back(ev);
          return 1'b1;
        end
      end
      DEC_FRAME: begin
        word_acc = {word_acc[WordW-2:0], band_hit(iv, REG_ONE_LOW)};
        bits_in++;
        if (bits_in >= FrameBits) begin
          ev = {EVENT_FRAME, word_acc, frame_count, repeat_count};
          event_q.push_back(ev);
          frame_count = frame_count + 1;
          dec_phase = DEC_IDLE;
          return 1'b1;
        end
      end
      default: begin
        dec_phase = DEC_ARMED;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic report_error(input string msg);
    if (err_count < 50) $display("ERROR at %0t: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (hold_for_drain && event_q.size() == 0) hold_for_drain = 1'b0;
      if (in_valid && in_ready) begin
        n_accepted++;
        if (decode_edge(edge_time)) begin
          n_emitted++;
          if (n_emitted % 4 == 0) hold_for_drain = 1'b1;
        end
      end
      if (!in_valid || in_ready) begin
        if (edge_q.size() != 0 && !hold_for_drain && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          edge_time <= edge_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    ir_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          report_error("event with no edge waiting for one");
        end else begin
          want = event_q.pop_front();
          if (want.kind == EVENT_FRAME) n_frames_checked++;
          else n_repeats_checked++;
          if (event_kind !== want.kind)
            report_error($sformatf("event_kind %b, expected %b", event_kind, want.kind));
          if (frame_word !== want.word)
            report_error($sformatf("frame_word %h, expected %h", frame_word, want.word));
          if (frames_seen !== want.frames)
            report_error($sformatf("frames_seen %0d, expected %0d", frames_seen, want.frames));
          if (repeats_seen !== want.repeats)
            report_error($sformatf("repeats_seen %0d, expected %0d", repeats_seen, want.repeats));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add_gap(input int iv);
    stamp = stamp + iv[TimeW-1:0];
    edge_q.push_back(stamp);
    n_queued++;
  endtask

  function automatic int pick_band(input int lo, input int hi);
    if (lo > hi) return -1;
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic arm_decoder();
    if (!gen_armed) add_gap($urandom_range(16'hFFFF));
    gen_armed = 1'b1;
  endtask

  // An interval that the armed decoder ignores: below the gap limit and in neither window.
  task automatic skip_gap();
    int iv;
    int tries;
    for (tries = 0; tries < 4; tries++) begin
      case ($urandom_range(4))
        0: iv = cfg_mirror[REG_LEADER_LOW];
        1: iv = cfg_mirror[REG_LEADER_HIGH];
        2: iv = cfg_mirror[REG_REPEAT_LOW];
        3: iv = cfg_mirror[REG_REPEAT_HIGH];
        default: iv = $urandom_range(16'hFFFF);
      endcase
      if (iv < cfg_mirror[REG_GAP_LIMIT] && !band_hit(iv[TimeW-1:0], REG_LEADER_LOW) &&
          !band_hit(iv[TimeW-1:0], REG_REPEAT_LOW)) begin
        add_gap(iv);
        break;
      end
    end
  endtask

  task automatic send_bits(input int count, input int noise_pct);
    int iv;
    int ol;
    int oh;
    ol = cfg_mirror[REG_ONE_LOW];
    oh = cfg_mirror[REG_ONE_HIGH];
    repeat (count) begin
      if ($urandom_range(99) < noise_pct) begin
        iv = $urandom_range(16'hFFFF);
      end else if ($urandom_range(1) == 1) begin
        iv = pick_band(ol + 1, oh - 1);
      end else begin
        case ($urandom_range(3))
          0: iv = ol;
          1: iv = oh;
          2: iv = $urandom_range(ol);
          default: iv = $urandom_range(16'hFFFF, oh);
        endcase
      end
      if (iv < 0) iv = $urandom_range(16'hFFFF);
      add_gap(iv);
    end
    gen_armed = 1'b0;
  endtask

  task automatic frame_burst(input int noise_pct);
    int lh;
    int gap;
    int iv;
    arm_decoder();
    lh = cfg_mirror[REG_LEADER_HIGH];
    gap = cfg_mirror[REG_GAP_LIMIT];
    iv = pick_band(cfg_mirror[REG_LEADER_LOW] + 1, ((lh < gap) ? lh : gap) - 1);
    if (iv >= 0) begin
      add_gap(iv);
      send_bits(FrameBits, noise_pct);
    end
  endtask

  task automatic repeat_burst();
    int rh;
    int gap;
    int iv;
    int tries;
    arm_decoder();
    rh = cfg_mirror[REG_REPEAT_HIGH];
    gap = cfg_mirror[REG_GAP_LIMIT];
    repeat ($urandom_range(4, 1)) begin
      if ($urandom_range(2) == 0) skip_gap();
      for (tries = 0; tries < 4; tries++) begin
        iv = pick_band(cfg_mirror[REG_REPEAT_LOW] + 1, ((rh < gap) ? rh : gap) - 1);
        if (iv >= 0 && !band_hit(iv[TimeW-1:0], REG_LEADER_LOW)) begin
          add_gap(iv);
          break;
        end
      end
    end
  endtask

  task automatic random_part(input int count);
    int base;
    int r;
    base = n_queued;
    while (n_queued - base < count) begin
      r = $urandom_range(99);
      if (r < 45) begin
        frame_burst(0);
      end else if (r < 55) begin
        frame_burst(50);
      end else if (r < 85) begin
        repeat_burst();
      end else if (r < 93) begin
        arm_decoder();
        add_gap(pick_band(cfg_mirror[REG_GAP_LIMIT], 16'hFFFF));
      end else begin
        arm_decoder();
        repeat ($urandom_range(3, 1)) skip_gap();
      end
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (edge_q.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [RegIdxW-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[TimeW-1:0];
    if (idx <= REG_GAP_LIMIT) cfg_mirror[idx] = val[TimeW-1:0];
  endtask

  task automatic apply_setting(input int ll, input int lh, input int rl, input int rh,
                               input int ol, input int oh, input int gl);
    write_reg(REG_LEADER_LOW, ll);
    write_reg(REG_LEADER_HIGH, lh);
    write_reg(REG_REPEAT_LOW, rl);
    write_reg(REG_REPEAT_HIGH, rh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_GAP_LIMIT, gl);
    // The spare index must leave every register untouched.
    write_reg(REG_SPARE, $urandom_range(16'hFFFF));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int warmup [0:24];
    int ll;
    int rl;
    int ol;
    cfg_mirror[REG_LEADER_LOW] = LEADER_LOW_RST;
    cfg_mirror[REG_LEADER_HIGH] = LEADER_HIGH_RST;
    cfg_mirror[REG_REPEAT_LOW] = REPEAT_LOW_RST;
    cfg_mirror[REG_REPEAT_HIGH] = REPEAT_HIGH_RST;
    cfg_mirror[REG_ONE_LOW] = ONE_LOW_RST;
    cfg_mirror[REG_ONE_HIGH] = ONE_HIGH_RST;
    cfg_mirror[REG_GAP_LIMIT] = GAP_LIMIT_RST;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Arming, window and gap boundaries, wraparound, then a leader and the first bits.
    warmup = '{16'hFFFF, 2000, 1300, 1400, 1100, 1200, 1101, 1199, 1999, 0, 65535, 1399,
               201, 239, 200, 240, 0, 65535, 220, 1, 210, 199, 241, 230, 2000};
    foreach (warmup[i]) add_gap(warmup[i]);
    send_bits(FrameBits - 13, 0);
    random_part(280);
    drain();

    send_idle_pct = 80;
    recv_idle_pct = 38;
    // Leader and repeat windows overlap; the leader must win.
    apply_setting(1200, 1300, 1250, 1400, 100, 400, 3000);
    random_part(250);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Widest windows, inverted repeat window, largest gap limit.
    apply_setting(0, 65535, 65535, 0, 0, 65535, 65535);
    random_part(150);
    drain();

    // Zero gap limit re-arms on every edge; empty one window.
    apply_setting(65535, 0, 0, 65535, 500, 500, 0);
    random_part(60);
    drain();

    ll = $urandom_range(1500, 800);
    rl = $urandom_range(700, 300);
    ol = $urandom_range(300, 50);
    apply_setting(ll, ll + $urandom_range(300, 2), rl, rl + $urandom_range(300, 2),
                  ol, ol + $urandom_range(100, 2), ll + $urandom_range(2300, 302));
    random_part(265);
    drain();

    $display("Covered %0d edges over %0d register settings, with stalls on both sides and none.",
             n_accepted, n_settings);
    $display("Checked %0d decoded frames and %0d repeat marks.",
             n_frames_checked, n_repeats_checked);
    if (err_count == 0) begin
      $display("ir_pulse_distance_decoder_top test passed");
    end else begin
      $display("ir_pulse_distance_decoder_top test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d events still expected.", event_q.size());
    $display("ir_pulse_distance_decoder_top test failed");
    $finish;
  end

endmodule
